// ===== rtl/pstc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the per-step tempo clock sequencer
// no dependencies; imported by every module of the block

package pstc_pkg;

	// step table geometry
	localparam int NUM_STEPS = 12;
	localparam int IDX_W     = $clog2(NUM_STEPS);

	// field widths
	localparam int SP_W    = 27;
	localparam int BPM_W   = 10;
	localparam int BEATS_W = 10;
	localparam int PHASE_W = 32;
	localparam int FIELD_IDX_W = 4;

	// reset values and arithmetic constants (time is unsigned q6.26 seconds)
	localparam logic [SP_W-1:0]    SP_RESET     = SP_W'(1398);
	localparam logic [PHASE_W-1:0] PERIOD_RESET = PHASE_W'(134217728);
	localparam logic [BEATS_W-1:0] BEATS_RESET  = BEATS_W'(4);
	localparam logic [PHASE_W-1:0] SIXTY_Q26    = PHASE_W'(64'd4026531840);
	localparam logic [BEATS_W-1:0] COUNT_MAX    = {BEATS_W{1'b1}};

	// serial divider: one quotient bit per cycle
	localparam int DIV_STEPS = PHASE_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// configuration port
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_SAMPLE_PERIOD = '0;

	// item kinds
	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic                   opcode;
		logic                   reset_level;
		logic [FIELD_IDX_W-1:0] step_index;
		logic                   step_enable;
		logic [BPM_W-1:0]       step_bpm;
		logic [BEATS_W-1:0]     step_beats;
	} pstc_item_t;

	typedef struct packed {
		logic                   gate;
		logic [FIELD_IDX_W-1:0] current_step;
		logic                   advanced;
	} pstc_result_t;

endpackage

// ===== rtl/pstc_div.sv =====
`timescale 1ns / 1ps
// restoring serial divider, one quotient bit per cycle
// depends on pstc_pkg

module pstc_div import pstc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [PHASE_W-1:0] dividend,
	input  logic [BPM_W-1:0]   divisor,
	output logic               done,
	output logic [PHASE_W-1:0] quotient
);

	logic               busy_q;
	logic               done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PHASE_W-1:0] dvd_q;
	logic [BPM_W-1:0]   rem_q;
	logic [BPM_W-1:0]   dsr_q;
	logic [BPM_W:0]     rem_shift;
	logic [BPM_W:0]     rem_diff;
	logic               q_bit;

	// shift in next dividend bit, trial subtract
	always_comb begin
		rem_shift = {rem_q, dvd_q[PHASE_W-1]};
		rem_diff  = rem_shift - {1'b0, dsr_q};
		q_bit     = (rem_shift >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PHASE_W-2:0], q_bit};
			rem_q <= q_bit ? rem_diff[BPM_W-1:0] : rem_shift[BPM_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule

// ===== rtl/pstc_seq.sv =====
`timescale 1ns / 1ps
// step tables, phase and beat state, and the sequencer that runs one item
// depends on pstc_pkg and pstc_div

module pstc_seq import pstc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [SP_W-1:0] sample_period,
	input  logic            item_valid,
	output logic            item_ready,
	input  pstc_item_t      item,
	input  logic            res_free,
	output logic            res_valid,
	output pstc_result_t    res
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_LOAD,
		S_ADD,
		S_SUB,
		S_GATE,
		S_SCAN,
		S_RST,
		S_DONE
	} state_t;

	state_t state_q;

	// step tables
	logic                enable_q [NUM_STEPS];
	logic [PHASE_W-1:0]  period_q [NUM_STEPS];
	logic [BEATS_W-1:0]  beats_q  [NUM_STEPS];

	// play state
	logic [IDX_W-1:0]    play_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [BEATS_W-1:0]  beat_q;
	logic                rst_seen_q;

	// per-item working registers
	pstc_item_t          item_q;
	logic [IDX_W-1:0]    widx_q;
	logic [IDX_W-1:0]    cand_q;
	logic [PHASE_W-1:0]  per_q;
	logic [BEATS_W-1:0]  hold_q;
	logic                gate_q;
	logic                adv_q;
	logic                res_valid_q;

	// write index range check
	logic [IDX_W+FIELD_IDX_W-1:0] idx_wide;
	logic                         idx_ok;
	logic [BPM_W-1:0]             bpm_eff;

	// divider hookup
	logic                div_start;
	logic                div_done;
	logic [PHASE_W-1:0]  div_quo;
	logic [PHASE_W-1:0]  div_dividend;

	// shared adder
	logic [PHASE_W:0]    add_a;
	logic [PHASE_W:0]    add_b;
	logic                add_cin;
	logic [PHASE_W+1:0]  add_sum;

	logic [IDX_W-1:0]    play_inc;
	logic [IDX_W-1:0]    cand_inc;
	logic [IDX_W+FIELD_IDX_W-1:0] play_wide;

	assign idx_wide = {{IDX_W{1'b0}}, item.step_index};
	assign idx_ok   = (idx_wide < (IDX_W+FIELD_IDX_W)'(NUM_STEPS));
	assign bpm_eff  = (item_q.step_bpm == '0) ? BPM_W'(1) : item_q.step_bpm;

	// rounding: add half the divisor before dividing
	assign div_dividend = SIXTY_Q26 + {{(PHASE_W-BPM_W+1){1'b0}}, bpm_eff[BPM_W-1:1]};

	pstc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (bpm_eff),
		.done     (div_done),
		.quotient (div_quo)
	);

	// one adder serves the phase add, the phase-period subtract and the gate compare
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_cin = 1'b0;
		case (state_q)
			S_ADD: begin
				add_a = {1'b0, phase_q};
				add_b = {{(PHASE_W+1-SP_W){1'b0}}, sample_period};
			end
			S_SUB: begin
				add_a   = {1'b0, phase_q};
				add_b   = ~{1'b0, per_q};
				add_cin = 1'b1;
			end
			S_GATE: begin
				add_a = {1'b0, per_q};
				add_b = ~{phase_q, 1'b0};
			end
			default: begin
				add_a = '0;
			end
		endcase
		add_sum = {1'b0, add_a} + {1'b0, add_b} + {{(PHASE_W+1){1'b0}}, add_cin};
	end

	assign play_inc = (play_q == IDX_W'(NUM_STEPS - 1)) ? '0 : play_q + 1'b1;
	assign cand_inc = (cand_q == IDX_W'(NUM_STEPS - 1)) ? '0 : cand_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			play_q      <= '0;
			phase_q     <= '0;
			beat_q      <= '0;
			rst_seen_q  <= 1'b0;
			res_valid_q <= 1'b0;
			div_start   <= 1'b0;
			for (int i = 0; i < NUM_STEPS; i++) begin
				enable_q[i] <= (i == 0);
				period_q[i] <= PERIOD_RESET;
				beats_q[i]  <= BEATS_RESET;
			end
		end else begin
			res_valid_q <= 1'b0;
			div_start   <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (item.opcode == OP_WRITE && idx_ok) begin
							div_start <= 1'b1;
							state_q   <= S_DIV;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						enable_q[widx_q] <= (widx_q == '0) ? 1'b1 : item_q.step_enable;
						period_q[widx_q] <= div_quo;
						beats_q[widx_q]  <= item_q.step_beats;
						state_q          <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= (item_q.opcode == OP_TICK) ? S_ADD : S_GATE;
				end
				S_ADD: begin
					// saturate on carry out of the phase word
					phase_q <= add_sum[PHASE_W] ? {PHASE_W{1'b1}} : add_sum[PHASE_W-1:0];
					state_q <= S_SUB;
				end
				S_SUB: begin
					if (add_sum[PHASE_W+1]) begin
						phase_q <= add_sum[PHASE_W-1:0];
						if (hold_q == '0) begin
							beat_q <= '0;
						end else if (beat_q != COUNT_MAX) begin
							beat_q <= beat_q + 1'b1;
						end
					end
					state_q <= S_GATE;
				end
				S_GATE: begin
					if (item_q.opcode == OP_TICK) begin
						if (beat_q >= hold_q && beat_q != '0) begin
							beat_q  <= '0;
							state_q <= S_SCAN;
						end else begin
							state_q <= S_RST;
						end
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					// step zero is always enabled, so the search ends
					if (enable_q[cand_q]) begin
						play_q  <= cand_q;
						state_q <= S_RST;
					end
				end
				S_RST: begin
					if (rst_seen_q) begin
						if (!item_q.reset_level) begin
							rst_seen_q <= 1'b0;
						end
					end else if (item_q.reset_level) begin
						rst_seen_q <= 1'b1;
						play_q     <= '0;
						phase_q    <= '0;
						beat_q     <= '0;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			item_q <= item;
			widx_q <= idx_wide[IDX_W-1:0];
			adv_q  <= 1'b0;
		end
		if (state_q == S_LOAD) begin
			per_q  <= period_q[play_q];
			hold_q <= beats_q[play_q];
		end
		if (state_q == S_GATE) begin
			gate_q <= add_sum[PHASE_W+1];
			cand_q <= play_inc;
			if (item_q.opcode == OP_TICK && beat_q >= hold_q && beat_q != '0) begin
				adv_q <= 1'b1;
			end
		end
		if (state_q == S_SCAN && !enable_q[cand_q]) begin
			cand_q <= cand_inc;
		end
	end

	assign play_wide = {{FIELD_IDX_W{1'b0}}, play_q};

	assign item_ready = (state_q == S_IDLE);
	assign res_valid  = res_valid_q;
	assign res.gate         = gate_q;
	assign res.current_step = play_wide[FIELD_IDX_W-1:0];
	assign res.advanced     = adv_q;

	// the playing step always indexes the table
	a_play_range: assert property (@(posedge clk) disable iff (!arst_n)
		play_q < IDX_W'(NUM_STEPS))
		else $error("play step out of range");

	// step zero can never be disabled
	a_step0_enabled: assert property (@(posedge clk) disable iff (!arst_n)
		enable_q[0])
		else $error("step zero disabled");

	// a quotient only arrives while a write waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside a write");

	// a result always returns the sequencer to idle
	a_res_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> state_q == S_IDLE && $past(state_q) == S_DONE)
		else $error("result issued out of sequence");

endmodule

// ===== rtl/per_step_tempo_clock_sequencer.sv =====
`timescale 1ns / 1ps
// per-step tempo clock sequencer top level: apb register, stream ports, output register
// depends on pstc_pkg and pstc_seq
//
// usage
//  - s_* stream takes one word per item; s_tuser is the item kind: 0 = sample tick,
//    1 = write one step entry (tempo, hold, enable). one result word per item on m_*
//  - apb register 0 (byte address 0) holds the sample period, unsigned q1.26 seconds,
//    reset 1398; write it only while no item is in flight
//  - an item takes its word, runs through a small sequencer, and the result lands in
//    an output register. the block takes no new word until that item is finished
//  - a tick loads the playing step, then adds the sample period to the phase, subtracts
//    the beat period and forms the gate on the shared phase adder in a row; when the
//    sequence advances it skips disabled steps, then applies reset and sends the result
//  - a step write waits on the serial divider that forms the beat period 60/bpm, one
//    quotient bit per cycle; an out-of-range index skips the divider
//  - a pending result in the output register does not block the next accept; if the
//    receiver stalls, a finished item waits in the sequencer until the register frees
//  - arst_n clears the step tables to their defaults (only step 0 enabled, 30 bpm,
//    hold of 4 beats), the play position, phase and beat count, and the register

module per_step_tempo_clock_sequencer import pstc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// apb configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// item input
	input  logic               s_tvalid,
	output logic               s_tready,
	// reset_level[0], step_index[4:1], step_enable[5], step_bpm[15:6], step_beats[25:16]
	input  logic [31:0]        s_tdata,
	// opcode[0]
	input  logic               s_tuser,
	// result output
	output logic               m_tvalid,
	input  logic               m_tready,
	// gate[0], current_step[4:1], advanced[5]
	output logic [7:0]         m_tdata
);

	logic [SP_W-1:0] sp_q;
	logic            cfg_wr;
	logic            reg_hit;

	pstc_item_t      item;
	pstc_result_t    res;
	logic            res_valid;
	logic            res_free;
	logic            seq_ready;

	logic            m_valid_q;
	pstc_result_t    m_res_q;

	// apb: zero wait states, writes on the access phase
	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_SAMPLE_PERIOD);
	assign cfg_wr  = psel && penable && pwrite && reg_hit;
	assign prdata  = reg_hit ? {{(32-SP_W){1'b0}}, sp_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= SP_RESET;
		end else if (cfg_wr) begin
			sp_q <= pwdata[SP_W-1:0];
		end
	end

	// unpack the input word
	always_comb begin
		item.opcode      = s_tuser;
		item.reset_level = s_tdata[0];
		item.step_index  = s_tdata[4:1];
		item.step_enable = s_tdata[5];
		item.step_bpm    = s_tdata[15:6];
		item.step_beats  = s_tdata[25:16];
	end

	// the output register can take a result when empty or being drained
	assign res_free = !m_valid_q || m_tready;

	pstc_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_period (sp_q),
		.item_valid    (s_tvalid),
		.item_ready    (seq_ready),
		.item          (item),
		.res_free      (res_free),
		.res_valid     (res_valid),
		.res           (res)
	);

	assign s_tready = seq_ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_res_q.advanced, m_res_q.current_step, m_res_q.gate};

endmodule

// ===== sim/per_step_tempo_clock_sequencer_tb.sv =====
`timescale 1ns / 1ps
// self-checking bench for the per-step tempo clock sequencer: directed corners, then random
// step writes and sample ticks across several sample periods; depends on pstc_pkg and the rtl

module per_step_tempo_clock_sequencer_tb;
	import pstc_pkg::*;

	localparam int          HOLDOFF_CYCLES = 300;
	localparam int          DRAIN_CYCLES   = 40;
	localparam int          NUM_PHASES     = 7;
	localparam logic [31:0] HOLD_ALL_MASK  = 32'hFFFF_FFFF;

	// tracks the step table, phase and beat count; queues the clock word each item should give
	class tempo_scoreboard;
		logic [SP_W-1:0]    sample_period;
		bit                 step_on [NUM_STEPS];
		logic [31:0]        period_tbl [NUM_STEPS];
		logic [BEATS_W-1:0] hold_tbl [NUM_STEPS];
		int unsigned        cur_step;
		logic [31:0]        phase;
		logic [BEATS_W-1:0] beat_cnt;
		bit                 rst_held;
		pstc_result_t       clock_out_due [$];
		int                 errors;

		function new();
			sample_period = SP_RESET;
			for (int i = 0; i < NUM_STEPS; i++) begin
				step_on[i]    = (i == 0);
				period_tbl[i] = PERIOD_RESET;
				hold_tbl[i]   = BEATS_RESET;
			end
			cur_step = 0;
			phase    = '0;
			beat_cnt = '0;
			rst_held = 1'b0;
			errors   = 0;
		endfunction

		// advance the sequencer by one accepted word and queue the clock word it yields
		function void take_item(pstc_item_t it);
			pstc_result_t    res;
			longint unsigned bpm, sum;
			logic [31:0]     per;
			logic [BEATS_W-1:0] hold;
			int unsigned     nxt;
			bit              found;
			res = '0;
			if (it.opcode == OP_WRITE) begin
				if (it.step_index < NUM_STEPS) begin
					bpm = (it.step_bpm == 0) ? 1 : it.step_bpm;
					step_on[it.step_index]    = (it.step_index == 0) ? 1'b1 : it.step_enable;
					period_tbl[it.step_index] = 32'((64'(SIXTY_Q26) + bpm / 2) / bpm);
					hold_tbl[it.step_index]   = it.step_beats;
				end
				res.gate = (64'(phase) * 2 < 64'(period_tbl[cur_step]));
			end else begin
				per  = period_tbl[cur_step];
				hold = hold_tbl[cur_step];
				sum  = 64'(phase) + 64'(sample_period);
				phase = (sum > 64'(HOLD_ALL_MASK)) ? HOLD_ALL_MASK : sum[31:0];
				if (phase >= per) begin
					if (hold != 0) begin
						if (beat_cnt != COUNT_MAX)
							beat_cnt = beat_cnt + 1'b1;
					end else begin
						beat_cnt = '0;
					end
					phase = phase - per;
				end
				res.gate = (64'(phase) * 2 < 64'(per));
				// hold reached: move to the next enabled step, wrapping past the end
				if (beat_cnt >= hold && beat_cnt != 0) begin
					beat_cnt = '0;
					nxt   = cur_step;
					found = 1'b0;
					for (int k = 1; k <= NUM_STEPS; k++) begin
						if (!found) begin
							nxt   = (cur_step + k) % NUM_STEPS;
							found = step_on[nxt];
						end
					end
					cur_step     = nxt;
					res.advanced = 1'b1;
				end
				// reset acts on the rising level only
				if (rst_held) begin
					if (!it.reset_level)
						rst_held = 1'b0;
				end else if (it.reset_level) begin
					rst_held = 1'b1;
					cur_step = 0;
					phase    = '0;
					beat_cnt = '0;
				end
			end
			res.current_step = FIELD_IDX_W'(cur_step);
			clock_out_due.push_back(res);
		endfunction

		function void compare_word(logic [7:0] word);
			pstc_result_t want;
			if (clock_out_due.size() == 0) begin
				$display("%0t: result word %h with nothing expected", $time, word);
				errors++;
				return;
			end
			want = clock_out_due.pop_front();
			if (word[0] !== want.gate) begin
				$display("%0t: gate expected %0d, got %0d", $time, want.gate, word[0]);
				errors++;
			end
			if (word[4:1] !== want.current_step) begin
				$display("%0t: current_step expected %0d, got %0d", $time,
					want.current_step, word[4:1]);
				errors++;
			end
			if (word[5] !== want.advanced) begin
				$display("%0t: advanced expected %0d, got %0d", $time, want.advanced, word[5]);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               s_tvalid;
	logic               s_tready;
	// reset_level[0], step_index[4:1], step_enable[5], step_bpm[15:6], step_beats[25:16]
	logic [31:0]        s_tdata;
	// opcode[0]
	logic               s_tuser;
	logic               m_tvalid;
	logic               m_tready;
	// gate[0], current_step[4:1], advanced[5]
	logic [7:0]         m_tdata;

	tempo_scoreboard sb;
	bit              hold_sink = 1'b0;

	per_step_tempo_clock_sequencer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pstc_item_t tick_word(logic rst);
		pstc_item_t it;
		it = '0;
		it.opcode      = OP_TICK;
		it.reset_level = rst;
		return it;
	endfunction

	function automatic pstc_item_t step_word(int unsigned idx, bit en, int unsigned bpm,
			int unsigned beats);
		pstc_item_t it;
		it = '0;
		it.opcode      = OP_WRITE;
		it.step_index  = FIELD_IDX_W'(idx);
		it.step_enable = en;
		it.step_bpm    = BPM_W'(bpm);
		it.step_beats  = BEATS_W'(beats);
		return it;
	endfunction

	// tempos are mostly picked so that a beat falls every 1 to 10 ticks at this sample period
	function automatic pstc_item_t random_item(logic [SP_W-1:0] sp);
		pstc_item_t      it;
		longint unsigned b;
		int unsigned     r;
		it.opcode      = ($urandom_range(0, 99) < 25) ? OP_WRITE : OP_TICK;
		it.reset_level = ($urandom_range(0, 99) < 6);
		it.step_index  = FIELD_IDX_W'(($urandom_range(0, 99) < 8)
			? $urandom_range(NUM_STEPS, 15) : $urandom_range(0, NUM_STEPS - 1));
		it.step_enable = ($urandom_range(0, 99) < 60);
		r = $urandom_range(0, 9);
		if (r == 0) begin
			b = $urandom_range(0, 1023);
		end else if (r == 1) begin
			b = $urandom_range(0, 1) ? $urandom_range(990, 1023) : $urandom_range(0, 2);
		end else begin
			b = (sp == 0) ? 1023 : 64'(SIXTY_Q26) / (64'(sp) * $urandom_range(1, 10));
			if (b == 0)
				b = 1;
			if (b > 1023)
				b = 1023;
		end
		it.step_bpm = BPM_W'(b);
		r = $urandom_range(0, 9);
		if (r < 7)
			it.step_beats = BEATS_W'($urandom_range(0, 5));
		else if (r < 9)
			it.step_beats = BEATS_W'($urandom_range(0, 1023));
		else
			it.step_beats = $urandom_range(0, 1) ? 10'd999 : 10'd1023;
		return it;
	endfunction

	// offer one word and hold it until the block takes it; valid stays up for the caller
	task automatic send_word(input pstc_item_t it);
		s_tvalid <= 1'b1;
		s_tuser  <= it.opcode;
		s_tdata  <= {6'b0, it.step_beats, it.step_bpm, it.step_enable, it.step_index,
			it.reset_level};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.take_item(it);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.clock_out_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_check(input logic [PADDR_W-1:0] addr, input logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want) begin
			$display("%0t: register %0d read expected %h, got %h", $time, addr, want, prdata);
			sb.errors++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// only with the block idle; the unused upper bits of the write carry noise
	task automatic program_sample_period(input logic [SP_W-1:0] sp);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_SAMPLE_PERIOD, 2'b00};
		pwdata  <= {5'($urandom_range(0, 31)), sp};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.sample_period = sp;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		reg_check({REG_SAMPLE_PERIOD, 2'b00}, {5'b0, sp});
	endtask

	// compare every word the block hands over
	always @(posedge clk) begin
		if (arst_n === 1'b1 && m_tvalid && m_tready)
			sb.compare_word(m_tdata);
	end

	// receiver: ready runs and stalls, plus one long hold-off on request
	initial begin : result_sink
		int unsigned run_len, stall_len;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_sink) begin
				hold_sink = 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk) m_tready <= 1'b0;
			end
			run_len = $urandom_range(1, 24);
			repeat (run_len) @(posedge clk) m_tready <= 1'b1;
			stall_len = pick_gap();
			repeat (stall_len) @(posedge clk) m_tready <= 1'b0;
		end
	end

	initial begin : stimulus
		logic [SP_W-1:0] sp_plan [NUM_PHASES];
		int unsigned     len_plan [NUM_PHASES];
		int unsigned     p, i, gap;
		sb       = new();
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_check({REG_SAMPLE_PERIOD, 2'b00}, 32'(SP_RESET));

		// default sample period: reset level rise and hold, then table corners
		send_word(tick_word(1'b0));
		send_word(tick_word(1'b1));
		send_word(tick_word(1'b1));
		send_word(tick_word(1'b0));
		send_word(step_word(0, 1'b0, 999, 1));       // step zero stays enabled
		send_word(step_word(NUM_STEPS, 1'b1, 1023, 1023)); // index past the table
		send_word(step_word(15, 1'b1, 1023, 1023));
		send_word(step_word(11, 1'b1, 0, 0));        // zero tempo reads as 1 bpm
		send_word(step_word(5, 1'b1, 1023, 1023));

		// one second per tick: beats land every tick or every other tick
		program_sample_period(SP_W'(67108864));
		send_word(step_word(5, 1'b0, 1, 0));
		send_word(step_word(11, 1'b0, 60, 1));
		send_word(step_word(0, 1'b1, 30, 3));
		send_word(tick_word(1'b0));
		send_word(tick_word(1'b0));
		// hold dropped to zero under a nonzero count, lone step wraps onto itself
		send_word(step_word(0, 1'b1, 30, 0));
		send_word(tick_word(1'b0));
		// zero hold never advances
		send_word(step_word(0, 1'b1, 60, 0));
		send_word(tick_word(1'b0));
		send_word(tick_word(1'b0));
		// two enabled steps, walk across and back, then reset on top of an advance
		send_word(step_word(3, 1'b1, 1023, 1));
		send_word(step_word(0, 1'b1, 60, 1));
		send_word(tick_word(1'b0));
		send_word(tick_word(1'b0));
		send_word(tick_word(1'b1));

		sp_plan  = '{SP_W'(67108864), '1, SP_W'(4194304),
			SP_W'($urandom_range(1 << 20, 1 << 26)), SP_W'(1), SP_W'(0),
			SP_W'($urandom_range(1 << 16, 1 << 25))};
		len_plan = '{100, 90, 90, 90, 40, 40, 100};
		for (p = 0; p < NUM_PHASES; p++) begin
			program_sample_period(sp_plan[p]);
			// long receiver hold-off while words keep coming
			if (p == 2)
				hold_sink = 1'b1;
			for (i = 0; i < len_plan[p]; i++) begin
				if (i == len_plan[p] / 2)
					wait_drained();
				gap = ((i / 16) % 3 == 2) ? 0 : pick_gap();
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				send_word(random_item(sp_plan[p]));
			end
		end

		wait_drained();
		if (sb.errors == 0 && sb.clock_out_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog far beyond the slowest legal run
	initial begin : watchdog
		#(10_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== per_step_tempo_clock_sequencer.f =====
rtl/pstc_pkg.sv
rtl/pstc_div.sv
rtl/pstc_seq.sv
rtl/per_step_tempo_clock_sequencer.sv
sim/per_step_tempo_clock_sequencer_tb.sv
